[rtl/core/checksummed_frame_checker_unit_defines.svh]
// Assertion macros for the checker file fcc_checker.sv.
// Both expect clk and rst_n in scope.
`ifndef CHECKSUMMED_FRAME_CHECKER_UNIT_DEFINES_SVH
`define CHECKSUMMED_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define FCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcc: next-cycle check failed");

`endif

[rtl/core/fcc_pkg.sv]
package fcc_pkg;

  // Frames beyond this many bytes are flagged as too long
  localparam logic [15:0] MAX_FRAME_BYTES = 16'd2048;

  localparam logic [15:0] CK_TOP  = 16'h8000;
  localparam logic [15:0] CK_POLY = 16'h8005;
  localparam logic [15:0] LEN_SAT = 16'hFFFF;
  localparam logic [15:0] MIN_LEN = 16'd4;

  // Byte offsets within the header
  localparam logic [15:0] OFS_SUM_LO = 16'd0;
  localparam logic [15:0] OFS_SUM_HI = 16'd1;
  localparam logic [15:0] OFS_LEN_LO = 16'd2;
  localparam logic [15:0] OFS_LEN_HI = 16'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEN_BAD  = 3'd2,
    ST_SUM_BAD  = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // One request moving from the input register into the checker core
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       last;
  } step_t;

  // One frame verdict moving into the output register
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] checksum;
    logic [15:0] length;
  } result_t;

  // One checksum step: shift with conditional poly, then fold in prev:cur
  function automatic logic [15:0] ck_update(input logic [15:0] ck,
                                            input logic [7:0]  prev,
                                            input logic [7:0]  cur);
    logic [15:0] sh;
    sh = {ck[14:0], 1'b0};
    if ((ck & CK_TOP) != 16'd0) sh = sh ^ CK_POLY;
    return sh ^ {prev, cur};
  endfunction

endpackage

[rtl/core/fcc_in_reg.sv]
module fcc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              out_free,
  output fcc_pkg::step_t    step
);
  import fcc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       fire;
  logic       load;

  // A held byte moves on unless it closes a frame and the result slot is full
  assign fire     = valid_r && (!last_r || out_free);
  assign in_stall = valid_r && !fire;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign step.fire = fire;
  assign step.data = data_r;
  assign step.last = last_r;

endmodule

[rtl/core/fcc_core.sv]
module fcc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  fcc_pkg::step_t   step,
  output fcc_pkg::result_t res
);
  import fcc_pkg::*;

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] run_ck_r, run_ck_nxt;
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic [15:0] hdr_ck_r, hdr_ck_nxt;
  logic [15:0] hdr_len_r, hdr_len_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] len;
  status_t     status;

  // Per-byte update of the frame state
  always_comb begin
    ovf_nxt       = ovf_r;
    hdr_ck_nxt    = hdr_ck_r;
    hdr_len_nxt   = hdr_len_r;
    run_ck_nxt    = run_ck_r;
    prev_byte_nxt = prev_byte_r;

    if (byte_count_r >= MAX_FRAME_BYTES) ovf_nxt = 1'b1;

    if (byte_count_r == OFS_SUM_LO) begin
      hdr_ck_nxt[7:0] = step.data;
    end else if (byte_count_r == OFS_SUM_HI) begin
      hdr_ck_nxt[15:8] = step.data;
    end else if (byte_count_r == OFS_LEN_LO) begin
      hdr_len_nxt[7:0] = step.data;
    end else if (byte_count_r == OFS_LEN_HI) begin
      hdr_len_nxt[15:8] = step.data;
    end

    if (byte_count_r >= OFS_LEN_LO) begin
      run_ck_nxt    = ck_update(run_ck_r, prev_byte_r, step.data);
      prev_byte_nxt = step.data;
    end

    // Saturating length
    len = (byte_count_r != LEN_SAT) ? byte_count_r + 16'd1 : LEN_SAT;
    byte_count_nxt = len;
  end

  // Verdict, by priority
  always_comb begin
    if (ovf_nxt) begin
      status = ST_TOO_LONG;
    end else if (len < MIN_LEN) begin
      status = ST_SHORT;
    end else if (len != hdr_len_nxt) begin
      status = ST_LEN_BAD;
    end else if (run_ck_nxt != hdr_ck_nxt) begin
      status = ST_SUM_BAD;
    end else begin
      status = ST_OK;
    end
  end

  assign res.valid    = step.fire && step.last;
  assign res.status   = status;
  assign res.checksum = run_ck_nxt;
  assign res.length   = len;

  // Frame state; cleared after the closing byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step.fire && step.last)) begin
      byte_count_r <= '0;
      run_ck_r     <= '0;
      prev_byte_r  <= '0;
      hdr_ck_r     <= '0;
      hdr_len_r    <= '0;
      ovf_r        <= 1'b0;
    end else if (step.fire) begin
      byte_count_r <= byte_count_nxt;
      run_ck_r     <= run_ck_nxt;
      prev_byte_r  <= prev_byte_nxt;
      hdr_ck_r     <= hdr_ck_nxt;
      hdr_len_r    <= hdr_len_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

[rtl/core/fcc_out_reg.sv]
module fcc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  fcc_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_computed_checksum,
  output logic [15:0]      out_frame_length
);
  import fcc_pkg::*;

  logic        valid_r, valid_nxt;
  logic [2:0]  status_r;
  logic [15:0] ck_r;
  logic [15:0] len_r;

  // Slot can take a result if empty or being drained this cycle
  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= 3'(res.status);
      ck_r     <= res.checksum;
      len_r    <= res.length;
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_computed_checksum = ck_r;
  assign out_frame_length      = len_r;

endmodule

[rtl/core/checksummed_frame_checker_unit.sv]
// Frame checker: takes one received byte per cycle while in_stall is low, a
// rate set by the per-byte state update between the input register and the
// result register, and on the byte marked last offers one verdict (status,
// computed checksum, length) once that byte has passed both registers.
// Bytes 0-1 carry the expected checksum and bytes 2-3 the total length,
// little-endian; the checksum covers offset 2 onward. in_stall rises only
// while a held closing byte waits for a result that has not yet been taken.
module checksummed_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_computed_checksum,
  output logic [15:0] out_frame_length
);
  import fcc_pkg::*;

  step_t   step;
  result_t res;
  logic    out_free;

  // Input register
  fcc_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_free     (out_free),
    .step         (step)
  );

  // Frame state and checksum
  fcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  // Result register
  fcc_out_reg u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .res                   (res),
    .out_free              (out_free),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_computed_checksum (out_computed_checksum),
    .out_frame_length      (out_frame_length)
  );

endmodule

[rtl/core/fcc_checker.sv]
`include "checksummed_frame_checker_unit_defines.svh"

module fcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [15:0] out_computed_checksum,
  input logic [15:0] out_frame_length
);
  import fcc_pkg::*;

  logic [34:0] out_payload;

  assign out_payload = {out_status, out_computed_checksum, out_frame_length};

  // A stalled result stays offered
  `FCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled result keeps its payload
  `FCC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload))

  // Only defined status codes leave the block
  `FCC_ASSERT_IMP(a_status_code, out_valid, out_status <= 3'(ST_TOO_LONG))

  // Too short means fewer than four bytes
  `FCC_ASSERT_IMP(a_short_len, out_valid && (out_status == 3'(ST_SHORT)), out_frame_length < MIN_LEN)

  // An accepted frame has at least a full header
  `FCC_ASSERT_IMP(a_ok_len, out_valid && (out_status == 3'(ST_OK)), out_frame_length >= MIN_LEN)

endmodule

bind checksummed_frame_checker_unit fcc_checker u_fcc_checker (.*);

[tb/frame_verdict_checker.sv]
`timescale 1ns / 1ps

// Checksum arithmetic shared by the frame builder and the verdict predictor
package frame_sum_pkg;

  // One step: shift left, fold in the polynomial if the top bit was set,
  // then xor in the previous and current byte as one 16-bit word
  function automatic logic [15:0] sum_step(input logic [15:0] acc,
                                           input logic [7:0]  prev,
                                           input logic [7:0]  cur);
    logic [15:0] nxt;
    nxt = {acc[14:0], 1'b0};
    if (acc[15]) nxt = nxt ^ fcc_pkg::CK_POLY;
    return nxt ^ {prev, cur};
  endfunction

endpackage

// Watches both channels, predicts each frame verdict and compares it
module frame_verdict_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_computed_checksum,
  input  logic [15:0] out_frame_length,
  output int          fail_count,
  output int          verdicts_due
);
  import fcc_pkg::*;
  import frame_sum_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] checksum;
    logic [15:0] length;
  } verdict_t;

  verdict_t verdict_q[$];
  int       errors = 0;

  // Predictor state for the frame in progress
  logic [15:0] byte_cnt;
  logic [15:0] run_sum;
  logic [15:0] hdr_sum;
  logic [15:0] hdr_len;
  logic [7:0]  prev_byte;
  logic        long_seen;

  task automatic clear_frame();
    byte_cnt  = '0;
    run_sum   = '0;
    hdr_sum   = '0;
    hdr_len   = '0;
    prev_byte = '0;
    long_seen = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    verdict_t    want;
    logic [15:0] idx;
    logic [15:0] len;
    status_t     st;
    if (!rst_n) begin
      clear_frame();
    end else begin
      // Result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $error("verdict: result with nothing expected (status %0d)", out_status);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_computed_checksum !== want.checksum) begin
            errors++;
            $error("computed_checksum: expected %h, got %h", want.checksum,
                   out_computed_checksum);
          end
          if (out_frame_length !== want.length) begin
            errors++;
            $error("frame_length: expected %0d, got %0d", want.length,
                   out_frame_length);
          end
        end
      end

      // Byte side: advance the frame and predict a verdict on the last byte
      if (in_valid && !in_stall) begin
        idx = byte_cnt;
        if (idx >= MAX_FRAME_BYTES) long_seen = 1'b1;
        case (idx)
          OFS_SUM_LO: hdr_sum[7:0]  = in_data_byte;
          OFS_SUM_HI: hdr_sum[15:8] = in_data_byte;
          OFS_LEN_LO: hdr_len[7:0]  = in_data_byte;
          OFS_LEN_HI: hdr_len[15:8] = in_data_byte;
          default: ;
        endcase
        if (idx >= OFS_LEN_LO) begin
          run_sum   = sum_step(run_sum, prev_byte, in_data_byte);
          prev_byte = in_data_byte;
        end
        len      = (idx != LEN_SAT) ? idx + 16'd1 : LEN_SAT;
        byte_cnt = len;
        if (in_last_byte) begin
          // too long beats too short beats length beats checksum
          if (long_seen)             st = ST_TOO_LONG;
          else if (len < MIN_LEN)    st = ST_SHORT;
          else if (len != hdr_len)   st = ST_LEN_BAD;
          else if (run_sum != hdr_sum) st = ST_SUM_BAD;
          else                       st = ST_OK;
          want.status   = st;
          want.checksum = run_sum;
          want.length   = len;
          verdict_q.push_back(want);
          clear_frame();
        end
      end
    end
    fail_count   <= errors;
    verdicts_due <= verdict_q.size();
  end

endmodule

[tb/checksummed_frame_checker_unit_tb.sv]
`timescale 1ns / 1ps

module checksummed_frame_checker_unit_tb;
  import frame_sum_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned RANDOM_PER_PH  = 550;

  typedef enum {FR_GOOD, FR_BAD_LEN, FR_BAD_SUM, FR_NOISE} frame_kind_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_computed_checksum;
  logic [15:0] out_frame_length;
  int          fail_count;
  int          verdicts_due;

  int          send_idle_pct = 38;
  int          recv_idle_pct = 67;
  int unsigned cycle_count   = 0;

  checksummed_frame_checker_unit u_dut (.*);

  frame_verdict_checker u_chk (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte request, idling first at random, and hold it until taken
  task automatic push_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and let every predicted verdict arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  // Build a frame with a consistent, deliberately broken or random header, then send it
  task automatic send_frame(input int unsigned len, input frame_kind_t kind);
    logic [7:0]  fb[$];
    logic [15:0] acc;
    logic [15:0] len_field;
    logic [7:0]  prev;
    int unsigned i;
    fb   = {};
    acc  = '0;
    prev = '0;
    for (i = 0; i < len; i++) fb.push_back(8'($urandom_range(255)));
    if (kind != FR_NOISE && len >= 4) begin
      len_field = len[15:0];
      if (kind == FR_BAD_LEN) len_field = len_field ^ 16'($urandom_range(1, 65535));
      fb[2] = len_field[7:0];
      fb[3] = len_field[15:8];
      for (i = 2; i < len; i++) begin
        acc  = sum_step(acc, prev, fb[i]);
        prev = fb[i];
      end
      if (kind == FR_BAD_SUM) acc = acc ^ 16'($urandom_range(1, 65535));
      fb[0] = acc[7:0];
      fb[1] = acc[15:8];
    end
    for (i = 0; i < len; i++) push_byte(fb[i], i == len - 1);
  endtask

  // Stimulus and verdict
  initial begin : stim
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int          phase;
    frame_kind_t kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // runts: one byte, two bytes (no checksum), three bytes (one step)
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hFF, 1'b1);
        // short frames: good, wrong length, wrong checksum, garbage header
        send_frame(4, FR_GOOD);
        send_frame(4, FR_BAD_LEN);
        send_frame(5, FR_BAD_SUM);
        send_frame(6, FR_NOISE);
      end

      // mostly well-formed frames, with runts, noise and broken headers mixed in
      sent = 0;
      while (sent < RANDOM_PER_PH) begin
        pick = $urandom_range(99);
        len  = $urandom_range(4, 24);
        if (pick < 10) begin
          len  = $urandom_range(1, 3);
          kind = FR_NOISE;
        end else if (pick < 20) begin
          len  = $urandom_range(1, 32);
          kind = FR_NOISE;
        end else if (pick < 32) kind = FR_BAD_LEN;
        else if (pick < 44)     kind = FR_BAD_SUM;
        else                    kind = FR_GOOD;
        send_frame(len, kind);
        sent += len;
      end

      // sender holds off until the block has delivered everything
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
